// ===== design/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing test.
// No dependencies; used by pip_front, pip_queue, pip_back and the top level.
`default_nettype none

package pip_pkg;

   localparam int COORD_W     = 32;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int CNT_W       = 8;
   localparam int VCNT_W      = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [VCNT_W-1:0] MIN_VERTICES = VCNT_W'(3);

   // One classified edge, front to back.
   typedef struct packed {
      logic                   first;
      logic                   last;
      logic                   crossing;
      logic                   vcnt_ok;
      logic                   boundary;
      logic [CNT_W-1:0]       total;
      logic [DIFF_W-1:0]      dxa;   // xa - qx
      logic [DIFF_W-1:0]      dyb;   // yb - ya
      logic [DIFF_W-1:0]      dqy;   // qy - ya
      logic [DIFF_W-1:0]      dxb;   // xb - xa
   } edge_item_type;

endpackage

`default_nettype wire

// ===== design/pip_front.sv =====
// Front end: takes vertex transfers, tracks query point, previous vertex,
// vertex and crossing counts and boundary hits; emits one edge item per vertex.
// Depends on pip_pkg.
`default_nettype none

module pip_front #(
   parameter int MAX_CROSSINGS = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [31:0]            query_x,
   input  wire logic [31:0]            query_y,
   input  wire logic [31:0]            vertex_x,
   input  wire logic [31:0]            vertex_y,
   input  wire logic                   first_vertex,
   input  wire logic                   last_vertex,
   output pip_pkg::edge_item_type      item
);

   logic signed [31:0]             point_x_ff, point_x_in;
   logic signed [31:0]             point_y_ff, point_y_in;
   logic signed [31:0]             prev_x_ff, prev_x_in;
   logic signed [31:0]             prev_y_ff, prev_y_in;
   logic [pip_pkg::VCNT_W-1:0]     vcnt_ff, vcnt_in;
   logic [pip_pkg::CNT_W-1:0]      total_ff, total_in;
   logic                           bhit_ff, bhit_in;

   logic signed [31:0] vx, vy;
   logic               up, horiz, span, crossing;
   logic signed [31:0] xa, ya, xb, yb;

   assign vx = $signed(vertex_x);
   assign vy = $signed(vertex_y);

   always_comb begin
      horiz = (prev_y_ff == vy);
      up    = (prev_y_ff < vy);
      span  = up ? (prev_y_ff <= point_y_ff && point_y_ff < vy)
                 : (vy < point_y_ff && point_y_ff <= prev_y_ff);
      xa    = up ? prev_x_ff : vx;
      ya    = up ? prev_y_ff : vy;
      xb    = up ? vx : prev_x_ff;
      yb    = up ? vy : prev_y_ff;
   end

   always_comb begin
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      vcnt_in    = vcnt_ff;
      total_in   = total_ff;
      bhit_in    = bhit_ff;
      crossing   = 1'b0;
      if (first_vertex) begin
         point_x_in = $signed(query_x);
         point_y_in = $signed(query_y);
         prev_x_in  = vx;
         prev_y_in  = vy;
         vcnt_in    = pip_pkg::VCNT_W'(1);
         total_in   = '0;
         bhit_in    = 1'b0;
      end else begin
         if (vcnt_ff < pip_pkg::MIN_VERTICES) begin
            vcnt_in = vcnt_ff + pip_pkg::VCNT_W'(1);
         end
         if (total_ff < pip_pkg::CNT_W'(MAX_CROSSINGS)) begin
            prev_x_in = vx;
            prev_y_in = vy;
            if (horiz) begin
               if (point_y_ff == prev_y_ff &&
                   (prev_x_ff <= point_x_ff || vx <= point_x_ff) &&
                   (prev_x_ff >= point_x_ff || vx >= point_x_ff)) begin
                  bhit_in = 1'b1;
               end
            end else if (span) begin
               crossing = 1'b1;
               total_in = total_ff + pip_pkg::CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      item.first    = first_vertex;
      item.last     = last_vertex;
      item.crossing = crossing;
      item.vcnt_ok  = (vcnt_in == pip_pkg::MIN_VERTICES);
      item.boundary = bhit_in;
      item.total    = total_in;
      item.dxa      = {xa[31], xa} - {point_x_ff[31], point_x_ff};
      item.dyb      = {yb[31], yb} - {ya[31], ya};
      item.dqy      = {point_y_ff[31], point_y_ff} - {ya[31], ya};
      item.dxb      = {xb[31], xb} - {xa[31], xa};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff <= '0;
         point_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         vcnt_ff    <= '0;
         total_ff   <= '0;
         bhit_ff    <= 1'b0;
      end else if (push) begin
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         vcnt_ff    <= vcnt_in;
         total_ff   <= total_in;
         bhit_ff    <= bhit_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pip_queue.sv =====
// Short edge queue between front and back end.
// Depends on pip_pkg.
`default_nettype none

module pip_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  pip_pkg::edge_item_type      push_item,
   output logic                        full,
   input  wire logic                   pop,
   output pip_pkg::edge_item_type      head,
   output logic                        not_empty
);

   localparam int PTR_W = $clog2(pip_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pip_pkg::QUEUE_DEPTH + 1);

   pip_pkg::edge_item_type slot_ff [pip_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == CNT_W'(pip_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + PTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(pip_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> $stable(count_ff))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== design/pip_back.sv =====
// Back end: exact crossing side test by two multiplies and a wide add,
// left/on-point counters and the inside decision into the result register.
// Depends on pip_pkg.
`default_nettype none

module pip_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  pip_pkg::edge_item_type      head,
   input  wire logic                   not_empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_inside
);

   logic                           adv;
   logic                           s1_valid_ff, s1_valid_in;
   pip_pkg::edge_item_type         s1_ff;
   logic signed [pip_pkg::PROD_W-1:0] prod1_ff, prod1_in;
   logic signed [pip_pkg::PROD_W-1:0] prod2_ff, prod2_in;
   logic [pip_pkg::CNT_W-1:0]      left_ff, left_in;
   logic                           on_ff, on_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           inside_ff, inside_in;
   logic signed [pip_pkg::SUM_W-1:0] sum;
   logic                           odd;

   assign adv         = !rsp_valid_ff || rsp_ready;
   assign pop         = adv && not_empty;
   assign s1_valid_in = not_empty;
   assign prod1_in    = $signed(head.dxa) * $signed(head.dyb);
   assign prod2_in    = $signed(head.dqy) * $signed(head.dxb);
   assign sum         = {prod1_ff[pip_pkg::PROD_W-1], prod1_ff}
                      + {prod2_ff[pip_pkg::PROD_W-1], prod2_ff};

   always_comb begin
      left_in = left_ff;
      on_in   = on_ff;
      if (s1_ff.first) begin
         left_in = '0;
         on_in   = 1'b0;
      end else if (s1_ff.crossing) begin
         if (sum[pip_pkg::SUM_W-1]) begin
            left_in = left_ff + pip_pkg::CNT_W'(1);
         end else if (sum == '0) begin
            on_in = 1'b1;
         end
      end
      odd       = left_in[0];
      inside_in = s1_ff.vcnt_ok &&
                  (s1_ff.boundary ||
                   (odd && left_in < s1_ff.total) ||
                   (on_in && !odd &&
                    ({1'b0, left_in} + (pip_pkg::CNT_W+1)'(1)) < {1'b0, s1_ff.total}));
      rsp_valid_in = adv ? (s1_valid_ff && s1_ff.last) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         left_ff      <= '0;
         on_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            s1_valid_ff <= s1_valid_in;
            if (s1_valid_ff) begin
               left_ff <= left_in;
               on_ff   <= on_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= head;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
         if (s1_valid_ff && s1_ff.last) begin
            inside_ff <= inside_in;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_inside = inside_ff;

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.last && adv |=> rsp_valid_ff)
      else $error("closing vertex produced no result");

   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.first && adv |=> left_ff == '0 && !on_ff)
      else $error("counters not cleared on first vertex");

   a_no_cross_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && adv && !s1_ff.first && !s1_ff.crossing |=> $stable(left_ff))
      else $error("left count moved without a crossing");

endmodule

`default_nettype wire

// ===== design/point_in_polygon_test.sv =====
// Point-in-polygon crossing test; one vertex transfer per cycle while not full.
// Result path: edge queue slot, then stage-1 registers, then result register.
// Throughput: 1 vertex per cycle when not full, set by the edge classification
// and count update in the front end; back end is a two-stage multiply/add pipe.
// Reset: synchronous, clears query point, previous vertex, counters and queue.
`default_nettype none

module point_in_polygon_test #(
   parameter int MAX_CROSSINGS = 128
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,  // query_x, query_y, vertex_x, vertex_y
   input  wire logic          req_tuser,  // first_vertex
   input  wire logic          req_tlast,  // last_vertex
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata   // inside_res, zero pad
);

   pip_pkg::edge_item_type push_item;
   pip_pkg::edge_item_type head;
   logic                   push, full, pop, not_empty, inside_res;

   assign req_tready = !full;
   assign push       = req_tvalid && !full;

   pip_front #(
      .MAX_CROSSINGS(MAX_CROSSINGS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .query_x      (req_tdata[31:0]),
      .query_y      (req_tdata[63:32]),
      .vertex_x     (req_tdata[95:64]),
      .vertex_y     (req_tdata[127:96]),
      .first_vertex (req_tuser),
      .last_vertex  (req_tlast),
      .item         (push_item)
   );

   pip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty)
   );

   pip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_inside (inside_res)
   );

   assign rsp_tdata = {7'b0, inside_res};

endmodule

`default_nettype wire
